@@ hdl/wdf_pkg.sv @@
// Shared types and constants for the wind drag force pipeline.
// No dependencies.
package wdf_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int ROOT_W  = DIFF_W;
  localparam int GAIN_W  = 16;
  localparam int FORCE_W = 32;
  localparam int REG_W   = 32;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_CENTRE_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTRE_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTRE_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_AIR_X    = 3'd4;
  localparam logic [IDX_W-1:0] REG_AIR_Y    = 3'd5;
  localparam logic [IDX_W-1:0] REG_AIR_Z    = 3'd6;
  localparam logic [IDX_W-1:0] REG_DRAG     = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [SQ_W-1:0]    sq_t;
  typedef logic        [ROOT_W-1:0]  root_t;
  typedef logic        [GAIN_W-1:0]  gain_t;
  typedef logic signed [FORCE_W-1:0] force_t;

  typedef struct packed {
    logic  in_zone;
    diff_t rx;
    diff_t ry;
    diff_t rz;
  } tag_t;

endpackage

@@ hdl/wind_drag_force_in_sphere_core.sv @@
// Top level: register file and the wind drag force pipeline.
// Depends on wdf_pkg, wdf_front, wdf_sqrt, wdf_force.
//
// Usage:
//   Raise start for one cycle with a particle's position and velocity on the
//   in_ ports. busy is always low, so a transaction is taken every cycle.
//   Each transaction yields one result on the out_ ports, marked by
//   out_strobe for exactly one cycle, once it has passed these stages:
//   3 front stages (zone test, squares), 25 square root stages (one root
//   bit each), 3 force stages (gain products, quadratic product, saturate).
//   Throughput is one transaction per cycle.
//   Outside the sphere the force is zero and out_in_zone is low.
//   The receiver cannot stall; results are never held.
//   Registers sit on the APB port at byte address 4*index; write them only
//   while no transaction is in flight.
//   Reset (rst_n low, synchronous) clears all registers to zero and
//   drops every transaction in flight.
module wind_drag_force_in_sphere_core #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wdf_pkg::ADDR_W-1:0]   paddr,
  input  logic [wdf_pkg::REG_W-1:0]    pwdata,
  output logic [wdf_pkg::REG_W-1:0]    prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  wdf_pkg::coord_t              in_particle_pos_x,
  input  wdf_pkg::coord_t              in_particle_pos_y,
  input  wdf_pkg::coord_t              in_particle_pos_z,
  input  wdf_pkg::coord_t              in_particle_vel_x,
  input  wdf_pkg::coord_t              in_particle_vel_y,
  input  wdf_pkg::coord_t              in_particle_vel_z,
  output logic                         out_strobe,
  output wdf_pkg::force_t              out_force_x,
  output wdf_pkg::force_t              out_force_y,
  output wdf_pkg::force_t              out_force_z,
  output logic                         out_in_zone
);
  import wdf_pkg::*;

  coord_t cx_r, cy_r, cz_r, ax_r, ay_r, az_r;
  logic [COORD_W-1:0] rad_r;
  logic [REG_W-1:0]   drag_r;
  logic [IDX_W-1:0]   idx;
  logic               wr;

  logic  f_vld, s_vld;
  tag_t  f_tag, s_tag;
  sq_t   f_rel2;
  root_t s_mag;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      cz_r   <= '0;
      rad_r  <= '0;
      ax_r   <= '0;
      ay_r   <= '0;
      az_r   <= '0;
      drag_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_CENTRE_X: cx_r   <= pwdata[COORD_W-1:0];
        REG_CENTRE_Y: cy_r   <= pwdata[COORD_W-1:0];
        REG_CENTRE_Z: cz_r   <= pwdata[COORD_W-1:0];
        REG_RADIUS:   rad_r  <= pwdata[COORD_W-1:0];
        REG_AIR_X:    ax_r   <= pwdata[COORD_W-1:0];
        REG_AIR_Y:    ay_r   <= pwdata[COORD_W-1:0];
        REG_AIR_Z:    az_r   <= pwdata[COORD_W-1:0];
        REG_DRAG:     drag_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTRE_X: prdata = REG_W'(cx_r);
      REG_CENTRE_Y: prdata = REG_W'(cy_r);
      REG_CENTRE_Z: prdata = REG_W'(cz_r);
      REG_RADIUS:   prdata = REG_W'(rad_r);
      REG_AIR_X:    prdata = REG_W'(ax_r);
      REG_AIR_Y:    prdata = REG_W'(ay_r);
      REG_AIR_Z:    prdata = REG_W'(az_r);
      REG_DRAG:     prdata = drag_r;
      default:      prdata = '0;
    endcase
  end

  wdf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start),
    .pos_x  (in_particle_pos_x),
    .pos_y  (in_particle_pos_y),
    .pos_z  (in_particle_pos_z),
    .vel_x  (in_particle_vel_x),
    .vel_y  (in_particle_vel_y),
    .vel_z  (in_particle_vel_z),
    .cen_x  (cx_r),
    .cen_y  (cy_r),
    .cen_z  (cz_r),
    .radius (rad_r),
    .air_x  (ax_r),
    .air_y  (ay_r),
    .air_z  (az_r),
    .vld_o  (f_vld),
    .tag_o  (f_tag),
    .rel2_o (f_rel2)
  );

  wdf_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (f_vld),
    .rad_i  (f_rel2),
    .tag_i  (f_tag),
    .vld_o  (s_vld),
    .root_o (s_mag),
    .tag_o  (s_tag)
  );

  wdf_force #(
    .FRAC (FRACTION_BITS)
  ) u_force (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s_vld),
    .mag_i  (s_mag),
    .tag_i  (s_tag),
    .k1     (drag_r[GAIN_W-1:0]),
    .k2     (drag_r[2*GAIN_W-1:GAIN_W]),
    .vld_o  (out_strobe),
    .fx_o   (out_force_x),
    .fy_o   (out_force_y),
    .fz_o   (out_force_z),
    .zone_o (out_in_zone)
  );

endmodule

@@ hdl/wdf_front.sv @@
// Front end: zone test and relative velocity, three register stages.
// Depends on wdf_pkg.
module wdf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  wdf_pkg::coord_t pos_x,
  input  wdf_pkg::coord_t pos_y,
  input  wdf_pkg::coord_t pos_z,
  input  wdf_pkg::coord_t vel_x,
  input  wdf_pkg::coord_t vel_y,
  input  wdf_pkg::coord_t vel_z,
  input  wdf_pkg::coord_t cen_x,
  input  wdf_pkg::coord_t cen_y,
  input  wdf_pkg::coord_t cen_z,
  input  logic [wdf_pkg::COORD_W-1:0] radius,
  input  wdf_pkg::coord_t air_x,
  input  wdf_pkg::coord_t air_y,
  input  wdf_pkg::coord_t air_z,
  output logic           vld_o,
  output wdf_pkg::tag_t  tag_o,
  output wdf_pkg::sq_t   rel2_o
);
  import wdf_pkg::*;

  logic  a_vld_r, b_vld_r, c_vld_r;
  diff_t dx_r, dy_r, dz_r, rx_a_r, ry_a_r, rz_a_r;
  diff_t rx_b_r, ry_b_r, rz_b_r;
  sq_t   sdx_r, sdy_r, sdz_r, srx_r, sry_r, srz_r, rad2_r;
  logic signed [SQ_W-1:0] pdx, pdy, pdz, prx, pry, prz;
  logic [SQ_W-1:0] dist2, rel2;
  tag_t  tag_r;
  sq_t   rel2_r;

  assign pdx = dx_r * dx_r;
  assign pdy = dy_r * dy_r;
  assign pdz = dz_r * dz_r;
  assign prx = rx_a_r * rx_a_r;
  assign pry = ry_a_r * ry_a_r;
  assign prz = rz_a_r * rz_a_r;
  assign dist2 = sdx_r + sdy_r + sdz_r;
  assign rel2  = srx_r + sry_r + srz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= DIFF_W'(cen_x) - DIFF_W'(pos_x);
    dy_r   <= DIFF_W'(cen_y) - DIFF_W'(pos_y);
    dz_r   <= DIFF_W'(cen_z) - DIFF_W'(pos_z);
    rx_a_r <= DIFF_W'(air_x) - DIFF_W'(vel_x);
    ry_a_r <= DIFF_W'(air_y) - DIFF_W'(vel_y);
    rz_a_r <= DIFF_W'(air_z) - DIFF_W'(vel_z);
    sdx_r  <= pdx;
    sdy_r  <= pdy;
    sdz_r  <= pdz;
    srx_r  <= prx;
    sry_r  <= pry;
    srz_r  <= prz;
    rad2_r <= SQ_W'(radius) * SQ_W'(radius);
    rx_b_r <= rx_a_r;
    ry_b_r <= ry_a_r;
    rz_b_r <= rz_a_r;
    tag_r.in_zone <= (dist2 <= rad2_r);
    tag_r.rx <= rx_b_r;
    tag_r.ry <= ry_b_r;
    tag_r.rz <= rz_b_r;
    rel2_r <= rel2;
  end

  assign vld_o  = c_vld_r;
  assign tag_o  = tag_r;
  assign rel2_o = rel2_r;

endmodule

@@ hdl/wdf_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on wdf_pkg.
module wdf_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  wdf_pkg::sq_t  rad_i,
  input  wdf_pkg::tag_t tag_i,
  output logic          vld_o,
  output wdf_pkg::root_t root_o,
  output wdf_pkg::tag_t tag_o
);
  import wdf_pkg::*;

  localparam int TW = SQ_W + 2;

  logic  vld_r  [0:ROOT_W];
  root_t root_r [0:ROOT_W];
  sq_t   rem_r  [0:ROOT_W];
  tag_t  tag_r  [0:ROOT_W];

  assign vld_r[0]  = vld_i;
  assign root_r[0] = '0;
  assign rem_r[0]  = rad_i;
  assign tag_r[0]  = tag_i;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int B = ROOT_W - 1 - g;
    logic [TW-1:0] trial;
    logic          take;
    assign trial = (TW'(root_r[g]) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = TW'(rem_r[g]) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[g+1] <= tag_r[g];
      if (take) begin
        rem_r[g+1]  <= rem_r[g] - trial[SQ_W-1:0];
        root_r[g+1] <= root_r[g] | (root_t'(1) << B);
      end else begin
        rem_r[g+1]  <= rem_r[g];
        root_r[g+1] <= root_r[g];
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W];
  assign root_o = root_r[ROOT_W];
  assign tag_o  = tag_r[ROOT_W];

endmodule

@@ hdl/wdf_force.sv @@
// Drag terms, sum and saturation, three register stages.
// Depends on wdf_pkg.
module wdf_force #(
  parameter int FRAC = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  wdf_pkg::root_t mag_i,
  input  wdf_pkg::tag_t  tag_i,
  input  wdf_pkg::gain_t k1,
  input  wdf_pkg::gain_t k2,
  output logic           vld_o,
  output wdf_pkg::force_t fx_o,
  output wdf_pkg::force_t fy_o,
  output wdf_pkg::force_t fz_o,
  output logic           zone_o
);
  import wdf_pkg::*;

  localparam int PW = GAIN_W + ROOT_W;
  localparam int QW = PW - FRAC;
  localparam int LW = GAIN_W + 1 + DIFF_W;
  localparam int MW = QW + 1 + DIFF_W;
  localparam int SW = MW + 1;

  logic a_vld_r, b_vld_r, c_vld_r;
  logic a_zone_r, b_zone_r, c_zone_r;
  logic [PW-1:0] qp;
  logic [QW-1:0] q_r;
  diff_t rx_r, ry_r, rz_r;
  logic signed [LW-1:0] lpx, lpy, lpz, lx_r, ly_r, lz_r, lx2_r, ly2_r, lz2_r;
  logic signed [MW-1:0] mx, my, mz, qx_r, qy_r, qz_r;
  logic signed [SW-1:0] sx, sy, sz;
  force_t fx_r, fy_r, fz_r;

  function automatic force_t sat(input logic signed [SW-1:0] v);
    force_t r;
    if (v > SW'(signed'({1'b0, {(FORCE_W-1){1'b1}}}))) begin
      r = {1'b0, {(FORCE_W-1){1'b1}}};
    end else if (v < -SW'(signed'({1'b0, {(FORCE_W-1){1'b1}}})) - SW'(1)) begin
      r = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      r = v[FORCE_W-1:0];
    end
    return r;
  endfunction

  assign qp  = PW'(k2) * PW'(mag_i);
  assign lpx = $signed({1'b0, k1}) * tag_i.rx;
  assign lpy = $signed({1'b0, k1}) * tag_i.ry;
  assign lpz = $signed({1'b0, k1}) * tag_i.rz;
  assign mx  = $signed({1'b0, q_r}) * rx_r;
  assign my  = $signed({1'b0, q_r}) * ry_r;
  assign mz  = $signed({1'b0, q_r}) * rz_r;
  assign sx  = SW'(lx2_r) + SW'(qx_r);
  assign sy  = SW'(ly2_r) + SW'(qy_r);
  assign sz  = SW'(lz2_r) + SW'(qz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r      <= qp[PW-1:FRAC];
    rx_r     <= tag_i.rx;
    ry_r     <= tag_i.ry;
    rz_r     <= tag_i.rz;
    lx_r     <= lpx >>> FRAC;
    ly_r     <= lpy >>> FRAC;
    lz_r     <= lpz >>> FRAC;
    a_zone_r <= tag_i.in_zone;
    qx_r     <= mx >>> FRAC;
    qy_r     <= my >>> FRAC;
    qz_r     <= mz >>> FRAC;
    lx2_r    <= lx_r;
    ly2_r    <= ly_r;
    lz2_r    <= lz_r;
    b_zone_r <= a_zone_r;
    c_zone_r <= b_zone_r;
    fx_r     <= b_zone_r ? sat(sx) : '0;
    fy_r     <= b_zone_r ? sat(sy) : '0;
    fz_r     <= b_zone_r ? sat(sz) : '0;
  end

  assign vld_o  = c_vld_r;
  assign fx_o   = fx_r;
  assign fy_o   = fy_r;
  assign fz_o   = fz_r;
  assign zone_o = c_zone_r;

endmodule
